// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SPR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPR_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SPR_ASSERT(label, clk, rst, prop, msg)
`define SPR_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ----- hdl/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg
// Types, constants and control structs of the servo PWM ramp controller.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int ANGLE_W      = 8;
  localparam int DWELL_W      = 8;
  localparam int PULSE_W      = 16;
  localparam int CNT_W        = 16;
  localparam int REG_IDX_W    = 8;

  localparam int MAX_ANGLE = 180;
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = ANGLE_W'(MAX_ANGLE);

  localparam logic [ANGLE_W-1:0] RESET_ANGLE = 8'd90;
  localparam logic [PULSE_W-1:0] RESET_PULSE = 16'd1500;

  localparam logic [CNT_W-1:0]   RESET_FRAME_PERIOD = 16'd20000;
  localparam logic [CNT_W-1:0]   RESET_TICKS_PER_MS = 16'd1000;
  localparam logic [PULSE_W-1:0] RESET_PULSE_BASE   = 16'd400;
  localparam logic [PULSE_W-1:0] RESET_PULSE_SPAN   = 16'd2200;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_PERIOD = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_MS = 8'd1;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_BASE   = 8'd2;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_SPAN   = 8'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // angle * span stays below 2^24; dividing by MAX_ANGLE is done as a
  // multiply by a rounded-up reciprocal, exact for every such product.
  localparam int PROD_W      = ANGLE_W + PULSE_W;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MAX_ANGLE) - 64'd1) / 64'(MAX_ANGLE));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic               op;
    logic [CH_W-1:0]    channel;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] target_angle;
    logic [DWELL_W-1:0] step_ms;
  } in_word_t;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] pin_levels;
    logic [NUM_CHANNELS-1:0] moving_mask;
    logic [PULSE_W-1:0]      reported_pulse;
    logic [ANGLE_W-1:0]      reported_angle;
  } out_word_t;

  typedef struct packed {
    logic            accept_tick;
    logic            accept_move;
    logic            out_load_now;
    logic            out_load_result;
    logic            scan_step;
    logic [CH_W-1:0] scan_idx;
  } cmd_t;

  typedef struct packed {
    logic ms_event;
    logic needs_calc;
    logic calc_done;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/spr_pulse_unit.sv -----
// ----------------------------------------------------------------------------
// spr_pulse_unit
// Two-stage angle to pulse width conversion: base + angle * span / MAX_ANGLE.
// ----------------------------------------------------------------------------
module spr_pulse_unit
  import spr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ANGLE_W-1:0] angle,
  input  logic [PULSE_W-1:0] span,
  input  logic [PULSE_W-1:0] base,
  output logic               done,
  output logic [PULSE_W-1:0] pulse
);

  logic                       s1_valid;
  logic                       s2_valid;
  logic [PROD_W-1:0]          prod;
  logic [PULSE_W-1:0]         quot;
  logic [PROD_W+RECIP_W-1:0]  recip_prod;
  logic [PULSE_W:0]           sum;

  assign recip_prod = (PROD_W+RECIP_W)'(prod) * (PROD_W+RECIP_W)'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(angle) * PROD_W'(span);
    end
    if (s1_valid) begin
      quot <= recip_prod[RECIP_SHIFT +: PULSE_W];
    end
  end

  assign sum   = {1'b0, base} + {1'b0, quot};
  assign pulse = sum[PULSE_W] ? {PULSE_W{1'b1}} : sum[PULSE_W-1:0];
  assign done  = s2_valid;

endmodule

// ----- hdl/spr_datapath.sv -----
// ----------------------------------------------------------------------------
// spr_datapath
// Configuration, frame and millisecond counters, channel ramp state and the
// output register.
// ----------------------------------------------------------------------------
module spr_datapath
  import spr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  in_word_t             in_data,
  input  logic                 cfg_valid,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_word_t            out_data
);

  logic [CNT_W-1:0]   frame_period;
  logic [CNT_W-1:0]   ticks_per_ms;
  logic [PULSE_W-1:0] pulse_base;
  logic [PULSE_W-1:0] pulse_span;

  logic [CNT_W-1:0]   frame_count;
  logic [CNT_W-1:0]   ms_prescale;

  logic [ANGLE_W-1:0]      cur_angle   [NUM_CHANNELS];
  logic [ANGLE_W-1:0]      goal_angle  [NUM_CHANNELS];
  logic [DWELL_W-1:0]      dwell_ms    [NUM_CHANNELS];
  logic [DWELL_W-1:0]      dwell_count [NUM_CHANNELS];
  logic [PULSE_W-1:0]      pulse_width [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ramp_active;

  logic [NUM_CHANNELS-1:0] pins_hold;
  logic                    item_move;
  logic [CH_W-1:0]         item_ch;
  logic [CH_W-1:0]         calc_ch;

  logic [NUM_CHANNELS-1:0] pins_now;
  logic [CNT_W:0]          frame_inc;
  logic [CNT_W:0]          frame_limit;
  logic [CNT_W-1:0]        frame_count_next;
  logic [CNT_W:0]          ms_inc;
  logic [CNT_W:0]          ms_limit;

  logic [ANGLE_W-1:0] move_start;
  logic [ANGLE_W-1:0] move_goal;
  logic [DWELL_W-1:0] move_dwell;

  logic [CH_W-1:0]    idx;
  logic [DWELL_W:0]   scan_cnt_inc;
  logic               scan_expire;
  logic               scan_at_goal;
  logic [ANGLE_W-1:0] scan_angle_next;

  logic               calc_start;
  logic [ANGLE_W-1:0] calc_angle;
  logic               calc_done;
  logic [PULSE_W-1:0] calc_pulse;

  // A period register of zero counts as 65536.
  assign frame_inc        = {1'b0, frame_count} + 17'd1;
  assign frame_limit      = (frame_period == '0) ? 17'h10000 : {1'b0, frame_period};
  assign frame_count_next = (frame_inc >= frame_limit) ? '0 : frame_inc[CNT_W-1:0];
  assign ms_inc           = {1'b0, ms_prescale} + 17'd1;
  assign ms_limit         = (ticks_per_ms == '0) ? 17'h10000 : {1'b0, ticks_per_ms};

  always_comb begin
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      pins_now[n] = frame_count < pulse_width[n];
    end
  end

  assign move_start = (in_data.start_angle > ANGLE_LIMIT) ? ANGLE_LIMIT
                                                          : in_data.start_angle;
  assign move_goal  = (in_data.target_angle > ANGLE_LIMIT) ? ANGLE_LIMIT
                                                           : in_data.target_angle;
  assign move_dwell = (in_data.step_ms == '0) ? DWELL_W'(1) : in_data.step_ms;

  assign idx             = cmd.scan_idx;
  assign scan_cnt_inc    = {1'b0, dwell_count[idx]} + 9'd1;
  assign scan_expire     = !(scan_cnt_inc < {1'b0, dwell_ms[idx]});
  assign scan_at_goal    = cur_angle[idx] == goal_angle[idx];
  assign scan_angle_next = (cur_angle[idx] < goal_angle[idx]) ? cur_angle[idx] + 8'd1
                                                              : cur_angle[idx] - 8'd1;

  assign status.ms_event   = ms_inc >= ms_limit;
  assign status.needs_calc = ramp_active[idx] && scan_expire && !scan_at_goal;
  assign status.calc_done  = calc_done;
  assign status.out_free   = !out_valid || !out_stall;

  assign calc_start = cmd.accept_move || (cmd.scan_step && status.needs_calc);
  assign calc_angle = cmd.accept_move ? move_start : scan_angle_next;

  spr_pulse_unit u_pulse (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .angle (calc_angle),
    .span  (pulse_span),
    .base  (pulse_base),
    .done  (calc_done),
    .pulse (calc_pulse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= RESET_FRAME_PERIOD;
      ticks_per_ms <= RESET_TICKS_PER_MS;
      pulse_base   <= RESET_PULSE_BASE;
      pulse_span   <= RESET_PULSE_SPAN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_PERIOD: frame_period <= cfg_data;
        REG_TICKS_PER_MS: ticks_per_ms <= cfg_data;
        REG_PULSE_BASE:   pulse_base   <= cfg_data;
        REG_PULSE_SPAN:   pulse_span   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      ms_prescale <= '0;
    end else if (cmd.accept_tick) begin
      frame_count <= frame_count_next;
      ms_prescale <= status.ms_event ? '0 : ms_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NUM_CHANNELS; n++) begin
        cur_angle[n]   <= RESET_ANGLE;
        goal_angle[n]  <= RESET_ANGLE;
        dwell_ms[n]    <= '0;
        dwell_count[n] <= '0;
        pulse_width[n] <= RESET_PULSE;
      end
      ramp_active <= '0;
    end else begin
      if (cmd.accept_move) begin
        cur_angle[in_data.channel]   <= move_start;
        goal_angle[in_data.channel]  <= move_goal;
        dwell_ms[in_data.channel]    <= move_dwell;
        dwell_count[in_data.channel] <= '0;
        ramp_active[in_data.channel] <= 1'b1;
      end
      if (cmd.scan_step && ramp_active[idx]) begin
        if (!scan_expire) begin
          dwell_count[idx] <= scan_cnt_inc[DWELL_W-1:0];
        end else begin
          dwell_count[idx] <= '0;
          if (scan_at_goal) begin
            ramp_active[idx] <= 1'b0;
          end else begin
            cur_angle[idx] <= scan_angle_next;
          end
        end
      end
      if (calc_done) begin
        pulse_width[calc_ch] <= calc_pulse;
      end
    end
  end

  // The pin levels of a tick are taken before the ramps move.
  always_ff @(posedge clk) begin
    if (cmd.accept_tick) begin
      pins_hold <= pins_now;
    end
    if (cmd.accept_tick || cmd.accept_move) begin
      item_move <= cmd.accept_move;
      item_ch   <= in_data.channel;
    end
    if (cmd.accept_move) begin
      calc_ch <= in_data.channel;
    end else if (cmd.scan_step) begin
      calc_ch <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load_now || cmd.out_load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_now) begin
      out_data.pin_levels     <= pins_now;
      out_data.moving_mask    <= ramp_active;
      out_data.reported_pulse <= pulse_width[in_data.channel];
      out_data.reported_angle <= cur_angle[in_data.channel];
    end else if (cmd.out_load_result) begin
      out_data.pin_levels     <= item_move ? pins_now : pins_hold;
      out_data.moving_mask    <= ramp_active;
      out_data.reported_pulse <= pulse_width[item_ch];
      out_data.reported_angle <= cur_angle[item_ch];
    end
  end

endmodule

// ----- hdl/spr_ctrl.sv -----
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer: accepts words, walks the channels on a millisecond event and
// waits on the pulse width unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spr_ctrl
  import spr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_op,
  input  status_t status,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t          state;
  state_t          state_next;
  logic [CH_W-1:0] scan_idx;
  logic            item_move;
  logic            accept;
  logic            scan_last;

  assign accept    = in_valid && (state == ST_IDLE) && status.out_free;
  assign in_stall  = !((state == ST_IDLE) && status.out_free);
  assign scan_last = scan_idx == CH_W'(NUM_CHANNELS - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_MOVE) begin
            state_next = ST_CALC;
          end else if (status.ms_event) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.needs_calc) begin
          state_next = ST_CALC;
        end else if (scan_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_CALC: begin
        if (status.calc_done) begin
          if (item_move || scan_last) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.scan_idx = scan_idx;
    case (state)
      ST_IDLE: begin
        cmd.accept_tick  = accept && (in_op == OP_TICK);
        cmd.accept_move  = accept && (in_op == OP_MOVE);
        cmd.out_load_now = accept && (in_op == OP_TICK) && !status.ms_event;
      end
      ST_SCAN:   cmd.scan_step       = 1'b1;
      ST_RESULT: cmd.out_load_result = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_idx  <= '0;
      item_move <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_idx  <= '0;
        item_move <= in_op == OP_MOVE;
      end else if ((state == ST_SCAN && !status.needs_calc && !scan_last) ||
                   (state == ST_CALC && status.calc_done && !item_move && !scan_last)) begin
        scan_idx <= scan_idx + CH_W'(1);
      end
    end
  end

  `SPR_ASSERT(a_done_in_calc, clk, rst, status.calc_done |-> state == ST_CALC, "pulse result outside calc state")
  `SPR_ASSERT(a_calc_latency, clk, rst, (state == ST_CALC && $past(state) != ST_CALC) |=> status.calc_done, "pulse unit latency mismatch")
  `SPR_ASSERT_NEVER(a_no_load_busy, clk, rst, (cmd.out_load_now || cmd.out_load_result) && !status.out_free, "output register overwritten")

endmodule

// ----- hdl/servo_pwm_ramp_controller_top.sv -----
// ----------------------------------------------------------------------------
// servo_pwm_ramp_controller_top
// Four-channel servo PWM generator with one-degree-per-step ramping.
// ----------------------------------------------------------------------------
// A tick word advances the PWM frame counter and the millisecond prescaler and
// returns the pin levels; a move word loads a channel's start angle, target
// angle and dwell. Every accepted word returns one result word. A tick with no
// millisecond event is handled in the idle state, so such ticks are accepted
// every cycle while the result side keeps up. A move goes through accept, the
// shared multiply unit that turns an angle into a pulse width, and a result
// state. A tick that ends a millisecond visits the channels one per cycle,
// except that each channel that steps an angle waits on the same multiply
// unit, and then goes to the result state. Configuration writes are always
// ready.
// ----------------------------------------------------------------------------
module servo_pwm_ramp_controller_top
  import spr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  spr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Servo PWM ramp controller testbench
// Drives tick and move words into the four-channel servo PWM block, predicts
// every result word with its own model of the frame counter, millisecond
// prescaler and angle ramps, and compares each field of each result.
// ----------------------------------------------------------------------------
module testbench;
  import spr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 20;

  // Indexes outside the register list; the block must ignore writes to them.
  localparam logic [REG_IDX_W-1:0] REG_PAST_END = REG_PULSE_SPAN + 8'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOP_IDX  = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  servo_pwm_ramp_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the servo block.
  logic [CNT_W-1:0]   frame_period_reg;
  logic [CNT_W-1:0]   ticks_per_ms_reg;
  logic [PULSE_W-1:0] pulse_base_reg;
  logic [PULSE_W-1:0] pulse_span_reg;
  int unsigned        frame_pos;
  int unsigned        ms_pos;
  logic [ANGLE_W-1:0] angle_now  [NUM_CHANNELS];
  logic [ANGLE_W-1:0] angle_goal [NUM_CHANNELS];
  logic [DWELL_W-1:0] dwell_len  [NUM_CHANNELS];
  logic [DWELL_W-1:0] dwell_cnt  [NUM_CHANNELS];
  logic               ramping    [NUM_CHANNELS];
  logic [PULSE_W-1:0] pulse_now  [NUM_CHANNELS];

  out_word_t pending_reports [$];

  int  error_count     = 0;
  int  words_accepted  = 0;
  int  moves_accepted  = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  cycle_count     = 0;
  int  stall_hold_cycles = 0;
  bit  idling_on       = 1'b1;

  function automatic void reset_servo_model();
    frame_period_reg = RESET_FRAME_PERIOD;
    ticks_per_ms_reg = RESET_TICKS_PER_MS;
    pulse_base_reg   = RESET_PULSE_BASE;
    pulse_span_reg   = RESET_PULSE_SPAN;
    frame_pos = 0;
    ms_pos    = 0;
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      angle_now[n]  = RESET_ANGLE;
      angle_goal[n] = RESET_ANGLE;
      dwell_len[n]  = '0;
      dwell_cnt[n]  = '0;
      ramping[n]    = 1'b0;
      pulse_now[n]  = RESET_PULSE;
    end
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_for_angle(logic [ANGLE_W-1:0] angle);
    int p;
    p = int'(pulse_base_reg) + (int'(angle) * int'(pulse_span_reg)) / MAX_ANGLE;
    return (p > 65535) ? 16'hFFFF : p[PULSE_W-1:0];
  endfunction

  function automatic logic [NUM_CHANNELS-1:0] pin_pattern();
    logic [NUM_CHANNELS-1:0] bits;
    bits = '0;
    for (int n = 0; n < NUM_CHANNELS; n++)
      bits[n] = (frame_pos < pulse_now[n]);
    return bits;
  endfunction

  function automatic logic [NUM_CHANNELS-1:0] ramp_pattern();
    logic [NUM_CHANNELS-1:0] bits;
    bits = '0;
    for (int n = 0; n < NUM_CHANNELS; n++)
      bits[n] = ramping[n];
    return bits;
  endfunction

  // One millisecond of dwell for every channel that is still ramping.
  function automatic void step_ramps();
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      if (ramping[n]) begin
        if (dwell_cnt[n] + 1 < dwell_len[n]) begin
          dwell_cnt[n] = dwell_cnt[n] + 8'd1;
        end else begin
          dwell_cnt[n] = '0;
          if (angle_now[n] == angle_goal[n]) begin
            ramping[n] = 1'b0;
          end else begin
            if (angle_now[n] < angle_goal[n]) angle_now[n] = angle_now[n] + 8'd1;
            else angle_now[n] = angle_now[n] - 8'd1;
            pulse_now[n] = pulse_for_angle(angle_now[n]);
          end
        end
      end
    end
  endfunction

  function automatic out_word_t next_servo_report(in_word_t word);
    out_word_t   r;
    int unsigned period_len;
    int unsigned ms_len;
    int unsigned ch;
    ch = word.channel;
    if (word.op == OP_TICK) begin
      period_len = (frame_period_reg == 0) ? 65536 : frame_period_reg;
      ms_len     = (ticks_per_ms_reg == 0) ? 65536 : ticks_per_ms_reg;
      r.pin_levels = pin_pattern();
      frame_pos = (frame_pos + 1 >= period_len) ? 0 : frame_pos + 1;
      if (ms_pos + 1 >= ms_len) begin
        ms_pos = 0;
        step_ramps();
      end else begin
        ms_pos = ms_pos + 1;
      end
    end else begin
      angle_now[ch]  = (word.start_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : word.start_angle;
      angle_goal[ch] = (word.target_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : word.target_angle;
      dwell_len[ch]  = (word.step_ms == 0) ? 8'd1 : word.step_ms;
      dwell_cnt[ch]  = '0;
      ramping[ch]    = 1'b1;
      pulse_now[ch]  = pulse_for_angle(angle_now[ch]);
      r.pin_levels   = pin_pattern();
    end
    r.moving_mask    = ramp_pattern();
    r.reported_pulse = pulse_now[ch];
    r.reported_angle = angle_now[ch];
    return r;
  endfunction

  function automatic void check_field(string field_name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
    end
  endfunction

  // Predict each accepted word first, then check any result leaving the block.
  always @(posedge clk) begin : report_check
    out_word_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_reports.push_back(next_servo_report(in_data));
        words_accepted++;
        if (in_data.op == OP_MOVE) moves_accepted++;
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_reports.size() == 0) begin
          error_count++;
          $display("%0t: result word with none expected, actual %h", $time, out_data);
        end else begin
          want = pending_reports.pop_front();
          check_field("pin_levels", want.pin_levels, out_data.pin_levels);
          check_field("moving_mask", want.moving_mask, out_data.moving_mask);
          check_field("reported_pulse", want.reported_pulse, out_data.reported_pulse);
          check_field("reported_angle", want.reported_angle, out_data.reported_angle);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result-side stall: random short bursts while idling is on, or a long hold when one is asked for.
  always begin : result_stall
    @(negedge clk);
    if (stall_hold_cycles > 0) begin
      out_stall <= 1'b1;
      repeat (stall_hold_cycles) @(negedge clk);
      stall_hold_cycles = 0;
      out_stall <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input in_word_t word);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tick(input logic [CH_W-1:0] ch);
    in_word_t word;
    word.op           = OP_TICK;
    word.channel      = ch;
    word.start_angle  = ANGLE_W'($urandom);
    word.target_angle = ANGLE_W'($urandom);
    word.step_ms      = DWELL_W'($urandom);
    send_word(word);
  endtask

  task automatic send_move(input logic [CH_W-1:0] ch, input logic [ANGLE_W-1:0] from_angle,
                           input logic [ANGLE_W-1:0] to_angle, input logic [DWELL_W-1:0] dwell);
    in_word_t word;
    word.op           = OP_MOVE;
    word.channel      = ch;
    word.start_angle  = from_angle;
    word.target_angle = to_angle;
    word.step_ms      = dwell;
    send_word(word);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (index)
      REG_FRAME_PERIOD: frame_period_reg = value;
      REG_TICKS_PER_MS: ticks_per_ms_reg = value;
      REG_PULSE_BASE:   pulse_base_reg   = value;
      REG_PULSE_SPAN:   pulse_span_reg   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [CNT_W-1:0] period, input logic [CNT_W-1:0] ms_len,
                                input logic [PULSE_W-1:0] base, input logic [PULSE_W-1:0] span);
    write_reg(REG_FRAME_PERIOD, period);
    write_reg(REG_TICKS_PER_MS, ms_len);
    write_reg(REG_PULSE_BASE, base);
    write_reg(REG_PULSE_SPAN, span);
  endtask

  // Mostly ticks; moves usually end a few degrees from where they start so
  // that ramps run to completion, with some full-range and saturating angles.
  function automatic in_word_t random_word();
    in_word_t word;
    int       goal;
    word.channel      = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    word.start_angle  = ANGLE_W'($urandom);
    word.target_angle = ANGLE_W'($urandom);
    word.step_ms      = DWELL_W'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      word.op = OP_MOVE;
      if ($urandom_range(0, 7) != 0) word.start_angle = ANGLE_W'($urandom_range(0, MAX_ANGLE));
      if ($urandom_range(0, 5) != 0) begin
        goal = int'(word.start_angle > ANGLE_LIMIT ? ANGLE_LIMIT : word.start_angle)
               + int'($urandom_range(0, 12)) - 6;
        if (goal < 0) goal = 0;
        if (goal > MAX_ANGLE) goal = MAX_ANGLE;
        word.target_angle = ANGLE_W'(goal);
      end
      if ($urandom_range(0, 7) != 0) word.step_ms = DWELL_W'($urandom_range(0, 3));
    end else begin
      word.op = OP_TICK;
    end
    return word;
  endfunction

  task automatic test_reset_state();
    send_tick(2'd0);
    send_tick(2'd3);
    wait_idle();
  endtask

  task automatic test_directed_moves();
    write_all_regs(16'd40, 16'd1, 16'd4, 16'd36);
    send_move(2'd0, 8'd0, 8'd3, 8'd0);      // zero dwell acts as one ms
    send_move(2'd1, 8'd180, 8'd178, 8'd2);  // ramp downward
    send_move(2'd2, 8'd255, 8'd200, 8'd1);  // both angles saturate, equal
    send_move(2'd3, 8'd90, 8'd90, 8'd255);  // longest dwell
    for (int i = 0; i < 8; i++) send_tick(CH_W'(i));
    wait_idle();
  endtask

  task automatic test_register_edges();
    write_all_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_move(2'd1, 8'd181, 8'd0, 8'd3);    // pulse width saturates
    send_tick(2'd1);
    wait_idle();
    write_reg(REG_PAST_END, 16'h1234);
    write_reg(REG_TOP_IDX, 16'hEDCB);
    send_tick(2'd2);
    wait_idle();
    // The frame counter is now past the new period and must wrap to zero.
    write_reg(REG_FRAME_PERIOD, 16'd5);
    send_tick(2'd0);
    send_tick(2'd0);
    wait_idle();
    // New base and span apply only to the next angle load.
    write_reg(REG_PULSE_BASE, 16'd0);
    write_reg(REG_PULSE_SPAN, 16'd180);
    send_tick(2'd1);
    send_move(2'd1, 8'd45, 8'd45, 8'd1);
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: write_all_regs(CNT_W'($urandom_range(1, 100)), CNT_W'($urandom_range(1, 3)),
                          PULSE_W'($urandom_range(0, 30)), PULSE_W'($urandom_range(0, 80)));
        1: write_all_regs(16'd1, 16'd1, 16'd0, PULSE_W'($urandom));
        2: write_all_regs((phase < 4) ? 16'hFFFF : 16'd0, CNT_W'($urandom_range(1, 2)),
                          PULSE_W'($urandom_range(60000, 65535)), 16'hFFFF);
        default: write_all_regs(CNT_W'($urandom), (phase < 4) ? 16'hFFFF : 16'd4,
                                PULSE_W'($urandom), PULSE_W'($urandom));
      endcase
      repeat (150) send_word(random_word());
      wait_idle();
    end
  endtask

  // Hold the result side long enough for the block to fill and stall its input.
  task automatic test_full_backpressure();
    write_all_regs(16'd50, 16'd1, 16'd10, 16'd60);
    stall_hold_cycles = 150;
    repeat (60) send_word(random_word());
    wait_idle();
  endtask

  task automatic test_quiet_finish();
    idling_on = 1'b0;
    write_all_regs(16'd64, 16'd2, 16'd5, 16'd90);
    repeat (270) send_word(random_word());
    wait_idle();
  endtask

  initial begin
    reset_servo_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_moves();
    test_register_edges();
    test_random_phases();
    test_full_backpressure();
    test_quiet_finish();

    $display("Ran %0d words (%0d moves), checked %0d results, made %0d register writes.",
             words_accepted, moves_accepted, results_checked, reg_writes);
    $display("Settings spanned zero, one and full-scale periods and saturating pulses.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
